@@ rtl/gem_pkg.sv @@
// Shared types and constants for the gamepad event to MIDI converter.
// Used by gamepad_event_to_midi and its checker; depends on nothing else.
package gem_pkg;

  typedef enum logic [1:0] {
    KIND_CC  = 2'd0,
    KIND_ON  = 2'd1,
    KIND_OFF = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] number;
    logic [6:0] data;
  } msg_t;

  localparam logic [2:0] REG_SPAN_LO   = 3'd0;
  localparam logic [2:0] REG_SPAN_HI   = 3'd1;
  localparam logic [2:0] REG_REST_POS  = 3'd2;
  localparam logic [2:0] REG_TRIG_FULL = 3'd3;
  localparam logic [2:0] REG_DEADZONE  = 3'd4;
  localparam logic [2:0] REG_CHAN      = 3'd5;
  localparam logic [2:0] REG_CC_BASE   = 3'd6;
  localparam logic [2:0] REG_NOTE_BASE = 3'd7;

  localparam logic [4:0] NUM_BUTTONS  = 5'd13;
  localparam logic [4:0] ID_DPAD_X    = 5'd13;
  localparam logic [4:0] ID_DPAD_Y    = 5'd14;
  localparam logic [4:0] ID_TRIG_L    = 5'd15;
  localparam logic [4:0] ID_TRIG_R    = 5'd16;
  localparam logic [4:0] ID_STICK_LX  = 5'd17;
  localparam logic [4:0] ID_STICK_RY  = 5'd20;

  localparam logic [6:0] VEL_ON       = 7'd127;
  localparam logic [6:0] VEL_OFF      = 7'd0;
  localparam logic [6:0] DATA_FULL    = 7'd127;
  localparam logic [6:0] DPAD_NOTE_OFS = 7'd14;
  localparam logic [6:0] STICK_CC_OFS = 7'd2;

  localparam logic signed [10:0] DPAD_NEG = -11'sd1;
  localparam logic signed [10:0] DPAD_POS = 11'sd1;

  localparam logic [2:0] DIV_LAST_STEP = 3'd7;

endpackage

@@ rtl/gamepad_event_to_midi.sv @@
// Gamepad event to MIDI converter: decodes one controller event into up to two messages.
// Depends on gem_pkg; trigger and stick scaling share one restoring divider.
//
//   channel   direction  handshake          payload
//   input     in         in_valid/in_ready  control_id, event_value
//   output    out        out_valid/out_ready msg_kind, midi_chan, msg_number, msg_data,
//                                            last_of_run
//   config    in         cfg_we             cfg_index, cfg_data
//
// A word is accepted in one cycle and decoded in the next.
// Trigger words and stick words that need scaling then pass through the shared divider:
// one overflow compare, which ends it at once on overflow, then one quotient bit
// per cycle.
// Each result word is then held on the output until it is taken.
// The block takes no new word until all results are taken; reset is synchronous.
module gamepad_event_to_midi (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         control_id,
  input  logic signed [10:0] event_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         msg_kind,
  output logic [3:0]         midi_chan,
  output logic [6:0]         msg_number,
  output logic [6:0]         msg_data,
  output logic               last_of_run,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  gem_pkg::state_t state, state_next;

  logic [9:0] span_lo, span_hi, rest_pos, trig_full, deadzone_width;
  logic [3:0] chan_sel;
  logic [6:0] cc_base, note_base;

  logic [12:0]        button_pressed;
  logic signed [10:0] stick_last [4];
  logic signed [10:0] dpad_last [2];

  logic [4:0]         ev_id;
  logic signed [10:0] ev_value;

  gem_pkg::msg_t msg0, msg1, cur_msg;
  logic          msg_two;
  logic          msg_idx;

  logic [17:0] rem;
  logic [16:0] dsh;
  logic [5:0]  quot;
  logic [2:0]  div_step;
  logic        div_slot;
  logic [18:0] div_diff;
  logic        div_ge;
  logic        div_done;

  logic               is_button, is_dpad, is_trig, is_stick;
  logic               dpad_a;
  logic [1:0]         stick_s;
  logic               pressed;
  logic signed [10:0] dpad_old;
  logic [6:0]         dpad_note;
  logic               dpad_has_off, dpad_has_on;
  gem_pkg::msg_t      dpad_off_msg, dpad_on_msg;
  logic signed [11:0] v12, c12, sdiff, sabs;
  logic signed [10:0] c11, filt;
  logic signed [11:0] f12;
  logic signed [10:0] den_neg, den_pos;
  logic [6:0]         stick_cc;

  gem_pkg::msg_t ev_msg0, ev_msg1;
  logic [1:0]    ev_count;
  logic          ev_div;
  logic          ev_slot;
  logic [11:0]   ev_num;
  logic [9:0]    ev_den;
  logic [18:0]   ev_prod;

  assign is_button = ev_id < gem_pkg::NUM_BUTTONS;
  assign is_dpad   = (ev_id == gem_pkg::ID_DPAD_X) || (ev_id == gem_pkg::ID_DPAD_Y);
  assign is_trig   = (ev_id == gem_pkg::ID_TRIG_L) || (ev_id == gem_pkg::ID_TRIG_R);
  assign is_stick  = (ev_id >= gem_pkg::ID_STICK_LX) && (ev_id <= gem_pkg::ID_STICK_RY);
  assign dpad_a    = (ev_id == gem_pkg::ID_DPAD_Y);
  assign stick_s   = 2'(ev_id - gem_pkg::ID_STICK_LX);
  assign pressed   = (ev_value != 11'sd0);

  assign dpad_old     = dpad_last[dpad_a];
  assign dpad_note    = 7'(note_base + gem_pkg::DPAD_NOTE_OFS + {5'd0, dpad_a, 1'b0});
  assign dpad_has_off = (dpad_old == gem_pkg::DPAD_NEG) || (dpad_old == gem_pkg::DPAD_POS);
  assign dpad_has_on  = (ev_value == gem_pkg::DPAD_NEG) || (ev_value == gem_pkg::DPAD_POS);

  always_comb begin
    dpad_off_msg.kind   = gem_pkg::KIND_OFF;
    dpad_off_msg.number = 7'(dpad_note + {6'd0, dpad_old == gem_pkg::DPAD_POS});
    dpad_off_msg.data   = gem_pkg::VEL_OFF;
    dpad_on_msg.kind    = gem_pkg::KIND_ON;
    dpad_on_msg.number  = 7'(dpad_note + {6'd0, ev_value == gem_pkg::DPAD_POS});
    dpad_on_msg.data    = gem_pkg::VEL_ON;
  end

  assign v12     = {ev_value[10], ev_value};
  assign c12     = {2'b00, rest_pos};
  assign c11     = {1'b0, rest_pos};
  assign sdiff   = v12 - c12;
  assign sabs    = sdiff[11] ? -sdiff : sdiff;
  assign filt    = (sabs <= $signed({2'b00, deadzone_width})) ? c11 : ev_value;
  assign f12     = {filt[10], filt};
  assign den_neg = c11 - $signed({1'b0, span_lo});
  assign den_pos = $signed({1'b0, span_hi}) - c11;
  assign stick_cc = 7'(cc_base + gem_pkg::STICK_CC_OFS + {4'd0, stick_s, 1'b0});

  always_comb begin
    ev_msg0  = '{gem_pkg::KIND_CC, 7'd0, 7'd0};
    ev_msg1  = '{gem_pkg::KIND_CC, 7'd0, 7'd0};
    ev_count = 2'd0;
    ev_div   = 1'b0;
    ev_slot  = 1'b0;
    ev_num   = 12'd0;
    ev_den   = 10'd0;
    if (is_button) begin
      if (pressed != button_pressed[ev_id[3:0]]) begin
        ev_count      = 2'd1;
        ev_msg0.kind  = pressed ? gem_pkg::KIND_ON : gem_pkg::KIND_OFF;
        ev_msg0.number = 7'(note_base + {2'd0, ev_id});
        ev_msg0.data  = pressed ? gem_pkg::VEL_ON : gem_pkg::VEL_OFF;
      end
    end else if (is_dpad) begin
      if (ev_value != dpad_old) begin
        ev_count = 2'({1'b0, dpad_has_off} + {1'b0, dpad_has_on});
        ev_msg0  = dpad_has_off ? dpad_off_msg : dpad_on_msg;
        ev_msg1  = dpad_on_msg;
      end
    end else if (is_trig) begin
      ev_count       = 2'd1;
      ev_msg0.number = 7'(cc_base + {6'd0, ev_id == gem_pkg::ID_TRIG_R});
      if (ev_value[10] || ev_value == 11'sd0) begin
        ev_msg0.data = 7'd0;
      end else if (trig_full == 10'd0) begin
        ev_msg0.data = gem_pkg::DATA_FULL;
      end else begin
        ev_div = 1'b1;
        ev_num = {2'b00, ev_value[9:0]};
        ev_den = trig_full;
      end
    end else if (is_stick) begin
      if (filt != stick_last[stick_s]) begin
        ev_count       = 2'd2;
        ev_msg0.number = stick_cc;
        ev_msg1.number = 7'(stick_cc + 7'd1);
        if (f12 < c12) begin
          ev_num = 12'(c12 - f12);
          ev_den = den_neg[9:0];
          if (den_neg[10] || den_neg == 11'sd0) begin
            ev_msg0.data = gem_pkg::DATA_FULL;
          end else begin
            ev_div = 1'b1;
          end
        end else if (f12 > c12) begin
          ev_num  = 12'(f12 - c12);
          ev_den  = den_pos[9:0];
          ev_slot = 1'b1;
          if (den_pos[10] || den_pos == 11'sd0) begin
            ev_msg1.data = gem_pkg::DATA_FULL;
          end else begin
            ev_div = 1'b1;
          end
        end
      end
    end
  end

  assign ev_prod = {ev_num, 7'd0} - {7'd0, ev_num};

  assign div_diff = {1'b0, rem} - {2'b00, dsh};
  assign div_ge   = !div_diff[18];
  assign div_done = ((div_step == 3'd0) && div_ge) || (div_step == gem_pkg::DIV_LAST_STEP);

  always_comb begin
    state_next = state;
    unique case (state)
      gem_pkg::S_IDLE: begin
        if (in_valid) state_next = gem_pkg::S_EVAL;
      end
      gem_pkg::S_EVAL: begin
        if (ev_div) state_next = gem_pkg::S_DIV;
        else if (ev_count != 2'd0) state_next = gem_pkg::S_EMIT;
        else state_next = gem_pkg::S_IDLE;
      end
      gem_pkg::S_DIV: begin
        if (div_done) state_next = gem_pkg::S_EMIT;
      end
      gem_pkg::S_EMIT: begin
        if (out_ready && (msg_idx || !msg_two)) state_next = gem_pkg::S_IDLE;
      end
      default: state_next = gem_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == gem_pkg::S_IDLE);
    out_valid   = (state == gem_pkg::S_EMIT);
    cur_msg     = msg_idx ? msg1 : msg0;
    msg_kind    = cur_msg.kind;
    midi_chan   = chan_sel;
    msg_number  = cur_msg.number;
    msg_data    = cur_msg.data;
    last_of_run = msg_idx || !msg_two;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gem_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_lo        <= 10'd0;
      span_hi        <= 10'd255;
      rest_pos       <= 10'd127;
      trig_full      <= 10'd255;
      deadzone_width <= 10'd15;
      chan_sel       <= 4'd0;
      cc_base        <= 7'd20;
      note_base      <= 7'd36;
      button_pressed <= '0;
      stick_last     <= '{default: 11'sd0};
      dpad_last      <= '{default: 11'sd0};
      msg_idx        <= 1'b0;
      div_step       <= 3'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gem_pkg::REG_SPAN_LO:   span_lo        <= cfg_data;
          gem_pkg::REG_SPAN_HI:   span_hi        <= cfg_data;
          gem_pkg::REG_REST_POS:  rest_pos       <= cfg_data;
          gem_pkg::REG_TRIG_FULL: trig_full      <= cfg_data;
          gem_pkg::REG_DEADZONE:  deadzone_width <= cfg_data;
          gem_pkg::REG_CHAN:      chan_sel       <= cfg_data[3:0];
          gem_pkg::REG_CC_BASE:   cc_base        <= cfg_data[6:0];
          gem_pkg::REG_NOTE_BASE: note_base      <= cfg_data[6:0];
          default: ;
        endcase
      end
      case (state)
        gem_pkg::S_EVAL: begin
          msg_idx  <= 1'b0;
          div_step <= 3'd0;
          if (is_button) begin
            button_pressed[ev_id[3:0]] <= pressed;
          end else if (is_dpad) begin
            dpad_last[dpad_a] <= ev_value;
          end else if (is_stick) begin
            stick_last[stick_s] <= filt;
          end
        end
        gem_pkg::S_DIV: begin
          div_step <= 3'(div_step + 3'd1);
        end
        gem_pkg::S_EMIT: begin
          if (out_ready) msg_idx <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gem_pkg::S_IDLE: begin
        ev_id    <= control_id;
        ev_value <= event_value;
      end
      gem_pkg::S_EVAL: begin
        msg0     <= ev_msg0;
        msg1     <= ev_msg1;
        msg_two  <= (ev_count == 2'd2);
        rem      <= ev_prod[17:0];
        dsh      <= {ev_den, 7'd0};
        quot     <= 6'd0;
        div_slot <= ev_slot;
      end
      gem_pkg::S_DIV: begin
        dsh <= {1'b0, dsh[16:1]};
        if (div_step == 3'd0) begin
          if (div_ge) begin
            if (div_slot) msg1.data <= gem_pkg::DATA_FULL;
            else msg0.data <= gem_pkg::DATA_FULL;
          end
        end else begin
          if (div_ge) rem <= div_diff[17:0];
          quot <= {quot[4:0], div_ge};
          if (div_step == gem_pkg::DIV_LAST_STEP) begin
            if (div_slot) msg1.data <= {quot, div_ge};
            else msg0.data <= {quot, div_ge};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/gem_chk.sv @@
// Port-level checker for gamepad_event_to_midi, bound to the top level.
// Depends on gem_pkg for the message kind codes and the note-on velocity.
module gem_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] msg_kind,
  input logic [6:0] msg_number,
  input logic [6:0] msg_data
);

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready did not drop after an accepted word");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (msg_kind == gem_pkg::KIND_CC) || (msg_kind == gem_pkg::KIND_ON) ||
                  (msg_kind == gem_pkg::KIND_OFF))
    else $error("illegal message kind");

  a_note_velocity: assert property (@(posedge clk) disable iff (rst)
    out_valid && (msg_kind == gem_pkg::KIND_ON) |-> msg_data == gem_pkg::VEL_ON)
    else $error("note on without full velocity");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(msg_number) && $stable(msg_data))
    else $error("stalled result word changed");

endmodule

bind gamepad_event_to_midi gem_chk u_gem_chk (.*);

@@ test/gamepad_event_to_midi_tb.sv @@
// Self-checking testbench for gamepad_event_to_midi: directed table, then random phases.
// Depends on gem_pkg and the RTL; an event translator or a table row predicts each word.
module gamepad_event_to_midi_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int WORDS_PER_PHASE = 98;
  localparam int NUM_PHASES = 8;
  localparam int NUM_ROWS = 24;

  typedef struct packed {
    gem_pkg::kind_t kind;
    logic [3:0]     chan;
    logic [6:0]     number;
    logic [6:0]     data;
    logic           last;
  } midi_word_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_ONE} row_mode_t;

  typedef struct packed {
    logic [4:0]         id;
    logic signed [10:0] val;
    row_mode_t          mode;
    gem_pkg::kind_t     kind;
    logic [6:0]         number;
    logic [6:0]         data;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [4:0]         control_id;
  logic signed [10:0] event_value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         msg_kind;
  logic [3:0]         midi_chan;
  logic [6:0]         msg_number;
  logic [6:0]         msg_data;
  logic               last_of_run;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [9:0]         cfg_data;

  int cfg_smin, cfg_smax, cfg_center, cfg_tmax, cfg_dz, cfg_chan, cfg_cc, cfg_note;
  bit button_down [13];
  int dpad_last [2];
  int stick_last [4];

  midi_word_t expected_midi [$];
  dir_row_t   dir_table [NUM_ROWS];
  row_mode_t  typed_mode;
  midi_word_t typed_word;
  int         mismatches;
  bit         gaps_on;
  bit         hold_long;

  gamepad_event_to_midi DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void reset_model();
    cfg_smin = 0;
    cfg_smax = 255;
    cfg_center = 127;
    cfg_tmax = 255;
    cfg_dz = 15;
    cfg_chan = 0;
    cfg_cc = 20;
    cfg_note = 36;
    foreach (button_down[i]) button_down[i] = 1'b0;
    foreach (dpad_last[i]) dpad_last[i] = 0;
    foreach (stick_last[i]) stick_last[i] = 0;
  endfunction

  function automatic midi_word_t make_msg(input gem_pkg::kind_t k, input int num,
                                          input int data);
    midi_word_t m;
    m.kind = k;
    m.chan = cfg_chan[3:0];
    m.number = num[6:0];
    m.data = data[6:0];
    m.last = 1'b0;
    return m;
  endfunction

  function automatic int scale_half(input int num, input int den);
    int q;
    if (den <= 0) return int'(gem_pkg::DATA_FULL);
    q = num * 127 / den;
    return (q > int'(gem_pkg::DATA_FULL)) ? int'(gem_pkg::DATA_FULL) : q;
  endfunction

  // Works out the MIDI words one event causes and updates the controller state.
  function automatic void translate_event(input logic [4:0] id, input logic signed [10:0] val,
                                          input bit keep);
    midi_word_t w [2];
    int n, v, a, s, neg_note, old, c, f, spread, d, negv, posv;
    n = 0;
    v = val;
    if (id < gem_pkg::NUM_BUTTONS) begin
      if (v != 0 && !button_down[id]) begin
        w[n] = make_msg(gem_pkg::KIND_ON, cfg_note + int'(id), gem_pkg::VEL_ON);
        n++;
      end else if (v == 0 && button_down[id]) begin
        w[n] = make_msg(gem_pkg::KIND_OFF, cfg_note + int'(id), gem_pkg::VEL_OFF);
        n++;
      end
      button_down[id] = (v != 0);
    end else if (id == gem_pkg::ID_DPAD_X || id == gem_pkg::ID_DPAD_Y) begin
      a = int'(id) - int'(gem_pkg::ID_DPAD_X);
      neg_note = cfg_note + int'(gem_pkg::DPAD_NOTE_OFS) + 2 * a;
      old = dpad_last[a];
      if (v != old) begin
        if (old == int'(gem_pkg::DPAD_NEG)) begin
          w[n] = make_msg(gem_pkg::KIND_OFF, neg_note, gem_pkg::VEL_OFF);
          n++;
        end
        if (old == int'(gem_pkg::DPAD_POS)) begin
          w[n] = make_msg(gem_pkg::KIND_OFF, neg_note + 1, gem_pkg::VEL_OFF);
          n++;
        end
        if (v == int'(gem_pkg::DPAD_NEG)) begin
          w[n] = make_msg(gem_pkg::KIND_ON, neg_note, gem_pkg::VEL_ON);
          n++;
        end else if (v == int'(gem_pkg::DPAD_POS)) begin
          w[n] = make_msg(gem_pkg::KIND_ON, neg_note + 1, gem_pkg::VEL_ON);
          n++;
        end
        dpad_last[a] = v;
      end
    end else if (id == gem_pkg::ID_TRIG_L || id == gem_pkg::ID_TRIG_R) begin
      if (v <= 0) d = 0;
      else if (cfg_tmax == 0) d = int'(gem_pkg::DATA_FULL);
      else begin
        d = v * 127 / cfg_tmax;
        if (d > int'(gem_pkg::DATA_FULL)) d = int'(gem_pkg::DATA_FULL);
      end
      w[n] = make_msg(gem_pkg::KIND_CC, cfg_cc + int'(id) - int'(gem_pkg::ID_TRIG_L), d);
      n++;
    end else if (id >= gem_pkg::ID_STICK_LX && id <= gem_pkg::ID_STICK_RY) begin
      s = int'(id) - int'(gem_pkg::ID_STICK_LX);
      c = cfg_center;
      spread = v - c;
      if (spread < 0) spread = -spread;
      f = (spread <= cfg_dz) ? c : v;
      if (f != stick_last[s]) begin
        negv = 0;
        posv = 0;
        if (f < c) negv = scale_half(c - f, c - cfg_smin);
        if (f > c) posv = scale_half(f - c, cfg_smax - c);
        w[0] = make_msg(gem_pkg::KIND_CC, cfg_cc + int'(gem_pkg::STICK_CC_OFS) + 2 * s, negv);
        w[1] = make_msg(gem_pkg::KIND_CC, cfg_cc + int'(gem_pkg::STICK_CC_OFS) + 2 * s + 1,
                        posv);
        n = 2;
        stick_last[s] = f;
      end
    end
    if (n > 0) w[n - 1].last = 1'b1;
    if (keep) for (int i = 0; i < n; i++) expected_midi.push_back(w[i]);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [4:0] id, input logic signed [10:0] val);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    control_id <= id;
    event_value <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[9:0];
    case (idx)
      gem_pkg::REG_SPAN_LO:   cfg_smin = value & 1023;
      gem_pkg::REG_SPAN_HI:   cfg_smax = value & 1023;
      gem_pkg::REG_REST_POS:  cfg_center = value & 1023;
      gem_pkg::REG_TRIG_FULL: cfg_tmax = value & 1023;
      gem_pkg::REG_DEADZONE:  cfg_dz = value & 1023;
      gem_pkg::REG_CHAN:      cfg_chan = value & 15;
      gem_pkg::REG_CC_BASE:   cfg_cc = value & 127;
      gem_pkg::REG_NOTE_BASE: cfg_note = value & 127;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_midi.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic apply_phase(input int p);
    int v [8];
    case (p)
      0: v = '{0, 255, 127, 255, 15, 0, 20, 36};
      1: v = '{0, 1023, 512, 1023, 0, 15, 127, 127};
      2: v = '{0, 0, 0, 0, 0, 0, 0, 0};
      3: v = '{1023, 1023, 1023, 1, 1023, 9, 117, 110};
      4: v = '{600, 100, 300, 700, 50, 3, 60, 80};
      default: begin
        v[0] = $urandom_range(0, 400);
        v[1] = $urandom_range(600, 1023);
        v[2] = $urandom_range(v[0], v[1]);
        v[3] = $urandom_range(1, 1023);
        v[4] = $urandom_range(0, 100);
        v[5] = $urandom_range(0, 15);
        v[6] = $urandom_range(0, 117);
        v[7] = $urandom_range(0, 110);
      end
    endcase
    write_reg(gem_pkg::REG_SPAN_LO, v[0]);
    write_reg(gem_pkg::REG_SPAN_HI, v[1]);
    write_reg(gem_pkg::REG_REST_POS, v[2]);
    write_reg(gem_pkg::REG_TRIG_FULL, v[3]);
    write_reg(gem_pkg::REG_DEADZONE, v[4]);
    write_reg(gem_pkg::REG_CHAN, v[5]);
    write_reg(gem_pkg::REG_CC_BASE, v[6]);
    write_reg(gem_pkg::REG_NOTE_BASE, v[7]);
    cfg_we <= 1'b0;
  endtask

  // Random event biased toward values that matter under the current settings.
  function automatic void pick_event(output logic [4:0] id, output logic signed [10:0] val,
                                     output bit counted);
    logic signed [10:0] any;
    int r, x, lo, hi;
    any = 11'($urandom);
    counted = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      id = 5'($urandom_range(0, int'(gem_pkg::NUM_BUTTONS) - 1));
      x = ($urandom_range(0, 1) == 0) ? 0 : int'(any);
    end else if (r < 45) begin
      id = ($urandom_range(0, 1) == 0) ? gem_pkg::ID_DPAD_X : gem_pkg::ID_DPAD_Y;
      x = ($urandom_range(0, 4) == 0) ? int'(any) : int'($urandom_range(0, 2)) - 1;
    end else if (r < 60) begin
      id = ($urandom_range(0, 1) == 0) ? gem_pkg::ID_TRIG_L : gem_pkg::ID_TRIG_R;
      case ($urandom_range(0, 4))
        0: x = any;
        1: x = $urandom_range(0, 2);
        default: x = $urandom_range(0, cfg_tmax + 40);
      endcase
    end else if (r < 95) begin
      id = 5'($urandom_range(int'(gem_pkg::ID_STICK_LX), int'(gem_pkg::ID_STICK_RY)));
      lo = (cfg_smin < cfg_smax) ? cfg_smin : cfg_smax;
      hi = (cfg_smin < cfg_smax) ? cfg_smax : cfg_smin;
      case ($urandom_range(0, 2))
        0: x = $urandom_range(lo, hi);
        1: x = cfg_center + int'($urandom_range(0, 2 * cfg_dz + 6)) - cfg_dz - 3;
        default: x = any;
      endcase
    end else begin
      id = 5'($urandom_range(int'(gem_pkg::ID_STICK_RY) + 1, 31));
      x = any;
      counted = 1'b0;
    end
    if (x > 1023) x = 1023;
    if (x < -1024) x = -1024;
    val = x[10:0];
  endfunction

  always @(posedge clk) begin : word_intake
    if (!rst && in_valid && in_ready) begin
      translate_event(control_id, event_value, typed_mode == ROW_PREDICT);
      if (typed_mode == ROW_ONE) expected_midi.push_back(typed_word);
    end
  end

  always @(posedge clk) begin : result_check
    midi_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_midi.size() == 0) begin
        report_mismatch("word with nothing expected, msg_number", msg_number, 0);
      end else begin
        want = expected_midi.pop_front();
        if (msg_kind != want.kind) report_mismatch("msg_kind", msg_kind, int'(want.kind));
        if (midi_chan != want.chan) report_mismatch("midi_chan", midi_chan, want.chan);
        if (msg_number != want.number) report_mismatch("msg_number", msg_number, want.number);
        if (msg_data != want.data) report_mismatch("msg_data", msg_data, want.data);
        if (last_of_run != want.last) report_mismatch("last_of_run", last_of_run, want.last);
      end
    end
  end

  initial begin : sink_pacing
    int hold_left;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        hold_left = LONG_HOLD;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [4:0] id;
    logic signed [10:0] val;
    bit counted;
    int taken, wait_left;
    rst = 1'b1;
    in_valid = 1'b0;
    control_id = '0;
    event_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gaps_on = 1'b1;
    hold_long = 1'b0;
    mismatches = 0;
    typed_mode = ROW_PREDICT;
    typed_word = '0;
    reset_model();
    dir_table = '{
      '{5'd0, 11'sd1, ROW_ONE, gem_pkg::KIND_ON, 7'd36, 7'd127},
      '{5'd0, 11'sd1, ROW_SILENT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::NUM_BUTTONS - 5'd1, 11'sh400, ROW_ONE, gem_pkg::KIND_ON, 7'd48, 7'd127},
      '{gem_pkg::NUM_BUTTONS - 5'd1, 11'sd0, ROW_ONE, gem_pkg::KIND_OFF, 7'd48, 7'd0},
      '{gem_pkg::ID_DPAD_X, -11'sd1, ROW_ONE, gem_pkg::KIND_ON, 7'd50, 7'd127},
      '{gem_pkg::ID_DPAD_X, 11'sd1, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_DPAD_X, 11'sd5, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_DPAD_X, 11'sd0, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_DPAD_Y, 11'sd1, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_DPAD_Y, 11'sd1023, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_TRIG_L, 11'sd1023, ROW_ONE, gem_pkg::KIND_CC, 7'd20, 7'd127},
      '{gem_pkg::ID_TRIG_R, 11'sh400, ROW_ONE, gem_pkg::KIND_CC, 7'd21, 7'd0},
      '{gem_pkg::ID_TRIG_L, 11'sd0, ROW_ONE, gem_pkg::KIND_CC, 7'd20, 7'd0},
      '{gem_pkg::ID_TRIG_R, 11'sd100, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_STICK_LX, 11'sd127, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_STICK_LX, 11'sd130, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_STICK_LX, 11'sd1023, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_STICK_LX + 5'd1, 11'sh400, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_STICK_LX + 5'd2, 11'sd0, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_STICK_RY, 11'sd200, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::ID_STICK_RY + 5'd1, 11'sd5, ROW_SILENT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{5'd31, -11'sd1, ROW_SILENT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::NUM_BUTTONS - 5'd2, 11'sd1, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0},
      '{gem_pkg::NUM_BUTTONS - 5'd3, 11'sd700, ROW_PREDICT, gem_pkg::KIND_CC, 7'd0, 7'd0}
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      typed_mode = dir_table[i].mode;
      typed_word = make_msg(dir_table[i].kind, dir_table[i].number, dir_table[i].data);
      typed_word.last = 1'b1;
      send_word(dir_table[i].id, dir_table[i].val);
    end
    typed_mode = ROW_PREDICT;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      apply_phase(p);
      gaps_on = (p != NUM_PHASES - 1);
      taken = 0;
      while (taken < WORDS_PER_PHASE) begin
        pick_event(id, val, counted);
        if (counted) taken++;
        if (counted && taken == 40 && (p == 1 || p == 4)) hold_long = 1'b1;
        send_word(id, val);
      end
    end

    in_valid <= 1'b0;
    wait_left = 5000;
    while (expected_midi.size() != 0 && wait_left > 0) begin
      @(negedge clk);
      wait_left--;
    end
    repeat (30) @(negedge clk);
    if (expected_midi.size() != 0)
      report_mismatch("words never produced", 0, expected_midi.size());
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
